[hdl/afp_pkg.sv]
// Shared types and constants for the frame admission filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package afp_pkg;

  // Configuration port widths and register indexes.
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_SERVER_PORT    = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_SERVER_ADDRESS = 4'd1;

  // Register reset values.
  localparam logic [15:0] SERVER_PORT_RESET    = 16'h0000;
  localparam logic [31:0] SERVER_ADDRESS_RESET = 32'hffff_ffff;

  // Protocol constants.
  localparam logic [15:0] TYPE_AOE     = 16'h88a2;
  localparam logic [15:0] TYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  VERSION_MASK = 8'hf0;
  localparam logic [7:0]  IHL_MASK     = 8'h0f;
  localparam logic [7:0]  IPV4_VERSION = 8'h40;
  localparam logic [3:0]  MIN_IHL      = 4'd5;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [31:0] ANY_ADDRESS  = 32'hffff_ffff;
  localparam logic [15:0] ANY_PORT     = 16'h0000;

  // Byte offsets within the frame.
  localparam logic [6:0] POS_TYPE_HI   = 7'd12;
  localparam logic [6:0] POS_TYPE_LO   = 7'd13;
  localparam logic [6:0] POS_VER_IHL   = 7'd14;
  localparam logic [6:0] POS_PROTOCOL  = 7'd23;
  localparam logic [6:0] POS_ADDR_FIRST = 7'd26;
  localparam logic [6:0] POS_ADDR_LAST  = 7'd29;
  localparam logic [6:0] POS_MAX       = 7'd127;

  // Verdict codes.
  typedef enum logic [3:0] {
    VERDICT_AOE         = 4'd0,
    VERDICT_UDP_OK      = 4'd1,
    VERDICT_BAD_TYPE    = 4'd2,
    VERDICT_BAD_VERSION = 4'd3,
    VERDICT_BAD_HLEN    = 4'd4,
    VERDICT_NOT_UDP     = 4'd5,
    VERDICT_PORT        = 4'd6,
    VERDICT_ADDRESS     = 4'd7,
    VERDICT_SHORT       = 4'd8
  } verdict_t;

  // Header fields as they stand after the current byte, with the byte count.
  typedef struct packed {
    logic [7:0]  count;
    logic [15:0] ether_type;
    logic [7:0]  version_and_ihl;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [15:0] source_port;
  } hdr_t;

endpackage

`default_nettype wire

[hdl/afp_capture.sv]
// Byte position counter and header field capture for the admission filter.
// Depends on afp_pkg.
`default_nettype none

module afp_capture (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    frame_byte,
  input  wire logic          end_of_frame,
  output afp_pkg::hdr_t      hdr_nxt
);
  import afp_pkg::*;

  logic [6:0]  pos_r,  pos_nxt;
  logic [15:0] type_r, type_nxt;
  logic [7:0]  vihl_r, vihl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] port_r, port_nxt;
  logic [3:0]  ihl;
  logic [6:0]  port_at;

  // The port offset follows the header length captured before this byte.
  assign ihl     = vihl_r[3:0];
  assign port_at = POS_VER_IHL + {1'b0, ihl, 2'b00};

  // Field updates for the byte at the current position.
  always_comb begin
    type_nxt  = type_r;
    vihl_nxt  = vihl_r;
    proto_nxt = proto_r;
    addr_nxt  = addr_r;
    port_nxt  = port_r;
    if (pos_r == POS_TYPE_HI) begin
      type_nxt = {frame_byte, type_r[7:0]};
    end else if (pos_r == POS_TYPE_LO) begin
      type_nxt = {type_r[15:8], frame_byte};
    end else if (pos_r == POS_VER_IHL) begin
      vihl_nxt = frame_byte;
    end else if (pos_r == POS_PROTOCOL) begin
      proto_nxt = frame_byte;
    end else if (pos_r >= POS_ADDR_FIRST && pos_r <= POS_ADDR_LAST) begin
      addr_nxt = {addr_r[23:0], frame_byte};
    end
    if (pos_r > POS_VER_IHL && ihl >= MIN_IHL) begin
      if (pos_r == port_at) begin
        port_nxt = {frame_byte, port_r[7:0]};
      end else if (pos_r == port_at + 7'd1) begin
        port_nxt = {port_r[15:8], frame_byte};
      end
    end
  end

  // Position saturates on long frames and restarts after the last byte.
  always_comb begin
    if (end_of_frame) begin
      pos_nxt = '0;
    end else if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + 7'd1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  assign hdr_nxt.count           = {1'b0, pos_r} + 8'd1;
  assign hdr_nxt.ether_type      = type_nxt;
  assign hdr_nxt.version_and_ihl = vihl_nxt;
  assign hdr_nxt.ip_protocol     = proto_nxt;
  assign hdr_nxt.source_address  = addr_nxt;
  assign hdr_nxt.source_port     = port_nxt;

  // Capture state, updated only for an accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      type_r  <= '0;
      vihl_r  <= '0;
      proto_r <= '0;
      addr_r  <= '0;
      port_r  <= '0;
    end else if (take) begin
      pos_r   <= pos_nxt;
      type_r  <= type_nxt;
      vihl_r  <= vihl_nxt;
      proto_r <= proto_nxt;
      addr_r  <= addr_nxt;
      port_r  <= port_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/afp_judge.sv]
// Verdict logic: checks the captured header against the configured server.
// Depends on afp_pkg.
`default_nettype none

module afp_judge (
  input  wire afp_pkg::hdr_t hdr,
  input  wire logic [15:0]   server_port,
  input  wire logic [31:0]   server_address,
  output afp_pkg::verdict_t  verdict
);
  import afp_pkg::*;

  logic [3:0] ihl;
  logic [7:0] port_need;

  assign ihl       = hdr.version_and_ihl[3:0];
  // Bytes needed to hold the whole UDP source port.
  assign port_need = 8'd16 + {2'b00, ihl, 2'b00};

  // The first failed check names the verdict.
  always_comb begin
    if (hdr.count < 8'd14) begin
      verdict = VERDICT_SHORT;
    end else if (hdr.ether_type == TYPE_AOE) begin
      verdict = VERDICT_AOE;
    end else if (hdr.ether_type != TYPE_IPV4) begin
      verdict = VERDICT_BAD_TYPE;
    end else if (hdr.count < 8'd15) begin
      verdict = VERDICT_SHORT;
    end else if ((hdr.version_and_ihl & VERSION_MASK) != IPV4_VERSION) begin
      verdict = VERDICT_BAD_VERSION;
    end else if (ihl < MIN_IHL) begin
      verdict = VERDICT_BAD_HLEN;
    end else if (hdr.count < 8'd24) begin
      verdict = VERDICT_SHORT;
    end else if (hdr.ip_protocol != PROTO_UDP) begin
      verdict = VERDICT_NOT_UDP;
    end else if (server_port != ANY_PORT && hdr.count < port_need) begin
      verdict = VERDICT_SHORT;
    end else if (server_port != ANY_PORT && hdr.source_port != server_port) begin
      verdict = VERDICT_PORT;
    end else if (server_address != ANY_ADDRESS && hdr.count < 8'd30) begin
      verdict = VERDICT_SHORT;
    end else if (server_address != ANY_ADDRESS && hdr.source_address != server_address) begin
      verdict = VERDICT_ADDRESS;
    end else begin
      verdict = VERDICT_UDP_OK;
    end
  end

endmodule

`default_nettype wire

[hdl/udp_aoe_frame_admission_filter_top.sv]
// Top level of the frame admission filter: configuration, capture, verdict and output.
// Depends on afp_pkg, afp_capture and afp_judge.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | frame_byte, end_of_frame
//   out_    | output    | out_valid/out_stall | admit, verdict
//   cfg_    | input     | cfg_valid/cfg_ready | index, data
//
// One byte is taken every cycle while in_stall is low; the verdict for a frame's last byte is
// registered in the output register, or in the skid entry when the output register is full and stalled.
// A two-entry output stage (register plus skid) lets bytes keep flowing while
// a verdict waits; in_stall rises only when both entries are full.
// Synchronous active-low reset clears the position, the output stage and the
// registers to their defaults. cfg_ready is always high.
`default_nettype none

module udp_aoe_frame_admission_filter_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_frame_byte,
  input  wire logic                          in_end_of_frame,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_admit,
  output logic [3:0]                         out_verdict,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [afp_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [afp_pkg::CfgDataW-1:0]  cfg_data
);
  import afp_pkg::*;

  logic        in_take;
  logic        res_valid;
  hdr_t        hdr_nxt;
  verdict_t    verdict;
  logic        res_admit;
  logic        out_take;

  logic [15:0] server_port_r;
  logic [31:0] server_address_r;

  logic        out_valid_r;
  logic        out_admit_r;
  logic [3:0]  out_verdict_r;
  logic        skid_valid_r;
  logic        skid_admit_r;
  logic [3:0]  skid_verdict_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_port_r    <= SERVER_PORT_RESET;
      server_address_r <= SERVER_ADDRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SERVER_PORT:    server_port_r    <= cfg_data[15:0];
        CFG_SERVER_ADDRESS: server_address_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Input handshake.
  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid && !in_stall;
  assign res_valid = in_take && in_end_of_frame;
  assign out_take  = out_valid_r && !out_stall;

  afp_capture u_capture (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (in_take),
    .frame_byte   (in_frame_byte),
    .end_of_frame (in_end_of_frame),
    .hdr_nxt      (hdr_nxt)
  );

  afp_judge u_judge (
    .hdr            (hdr_nxt),
    .server_port    (server_port_r),
    .server_address (server_address_r),
    .verdict        (verdict)
  );

  assign res_admit = (verdict == VERDICT_AOE) || (verdict == VERDICT_UDP_OK);

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_admit_r   <= skid_admit_r;
        out_verdict_r <= skid_verdict_r;
        skid_valid_r  <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_valid_r   <= 1'b1;
        out_admit_r   <= res_admit;
        out_verdict_r <= verdict;
      end else begin
        skid_valid_r   <= 1'b1;
        skid_admit_r   <= res_admit;
        skid_verdict_r <= verdict;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_admit   = out_admit_r;
  assign out_verdict = out_verdict_r;

endmodule

`default_nettype wire

[hdl/afp_checker.sv]
// Port-level checker for the frame admission filter, bound to the top level.
// Depends on afp_pkg and udp_aoe_frame_admission_filter_top.
`default_nettype none

module afp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_admit,
  input wire logic [3:0] out_verdict
);
  import afp_pkg::*;

  // A stalled request holds its verdict.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_admit) && $stable(out_verdict))
    else $error("stalled result changed");

  // Admission agrees with the verdict code.
  a_admit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_admit == (out_verdict == VERDICT_AOE || out_verdict == VERDICT_UDP_OK))
    else $error("admit disagrees with verdict");

  // Only defined verdict codes appear.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict <= VERDICT_SHORT)
    else $error("undefined verdict code");

  // Reset empties the output stage and releases the input.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output stage not cleared by reset");

endmodule

bind udp_aoe_frame_admission_filter_top afp_checker u_afp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_admit   (out_admit),
  .out_verdict (out_verdict)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the UDP/AoE frame admission filter.
// Depends on afp_pkg and udp_aoe_frame_admission_filter_top, and through it on afp_capture and afp_judge.
// Frames go in byte by byte; each verdict is checked against a predictor kept in step here.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afp_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 8;
  localparam int SETTLE       = 4;     // cycles after the last verdict before a register write
  localparam int QUIET_LIMIT  = 3000;  // cycles with no request moving before giving up
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_FRAMES = 2;
  localparam int HOLD_FRAMES  = 3;     // enough verdicts to fill the output stage and stall
  localparam int MAX_REPORTS  = 10;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 4'd15;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic     admit;
    verdict_t verdict;
  } verdict_rec_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_frame_byte = '0;
  logic                in_end_of_frame = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_admit;
  logic [3:0]          out_verdict;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Stimulus and expectation stores.
  byte_req_t    frame_bytes_q[$];
  verdict_rec_t pending_verdicts[$];

  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  logic        in_taken = 1'b0;

  // Predictor state: configuration copy and the fields captured from the frame.
  logic [15:0] want_port = SERVER_PORT_RESET;
  logic [31:0] want_addr = SERVER_ADDRESS_RESET;
  logic [6:0]  pos = '0;
  logic [15:0] etype = '0;
  logic [7:0]  ver_ihl = '0;
  logic [7:0]  proto = '0;
  logic [31:0] saddr = '0;
  logic [15:0] sport = '0;

  udp_aoe_frame_admission_filter_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_frame_byte   (in_frame_byte),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_admit       (out_admit),
    .out_verdict     (out_verdict),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Verdict for a frame of the given length, from the fields captured so far.
  function automatic verdict_t judge_frame(input int unsigned count);
    int unsigned ihl;
    int unsigned port_at;
    ihl = ver_ihl & IHL_MASK;
    port_at = POS_VER_IHL + 4 * ihl;
    if (count <= POS_TYPE_LO) return VERDICT_SHORT;
    if (etype == TYPE_AOE) return VERDICT_AOE;
    if (etype != TYPE_IPV4) return VERDICT_BAD_TYPE;
    if (count <= POS_VER_IHL) return VERDICT_SHORT;
    if ((ver_ihl & VERSION_MASK) != IPV4_VERSION) return VERDICT_BAD_VERSION;
    if (ihl < MIN_IHL) return VERDICT_BAD_HLEN;
    if (count <= POS_PROTOCOL) return VERDICT_SHORT;
    if (proto != PROTO_UDP) return VERDICT_NOT_UDP;
    if (want_port != ANY_PORT) begin
      if (count <= port_at + 1) return VERDICT_SHORT;
      if (sport != want_port) return VERDICT_PORT;
    end
    if (want_addr != ANY_ADDRESS) begin
      if (count <= POS_ADDR_LAST) return VERDICT_SHORT;
      if (saddr != want_addr) return VERDICT_ADDRESS;
    end
    return VERDICT_UDP_OK;
  endfunction

  // Advances the predictor by one frame byte; a verdict comes out on the last byte.
  function automatic void take_byte(input logic [7:0] b, input logic last,
                                    output logic done, output verdict_t v);
    int unsigned idx;
    int unsigned ihl;
    idx = pos;
    ihl = ver_ihl & IHL_MASK;
    if (idx == POS_TYPE_HI) etype[15:8] = b;
    else if (idx == POS_TYPE_LO) etype[7:0] = b;
    else if (idx == POS_VER_IHL) ver_ihl = b;
    else if (idx == POS_PROTOCOL) proto = b;
    else if (idx >= POS_ADDR_FIRST && idx <= POS_ADDR_LAST) saddr = {saddr[23:0], b};
    // The UDP source port sits right after the IP header and its options.
    if (idx > POS_VER_IHL && ihl >= MIN_IHL) begin
      if (idx == POS_VER_IHL + 4 * ihl) sport[15:8] = b;
      else if (idx == POS_VER_IHL + 1 + 4 * ihl) sport[7:0] = b;
    end
    if (pos < POS_MAX) pos = pos + 7'd1;
    done = last;
    v = VERDICT_AOE;
    if (last) begin
      v = judge_frame(idx + 1);
      pos = '0;
    end
  endfunction

  // Sender: offers the next byte at the falling edge, holding a stalled request.
  always @(negedge clk) begin : driver
    byte_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (frame_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      nxt = frame_bytes_q.pop_front();
      in_valid        <= 1'b1;
      in_frame_byte   <= nxt.data;
      in_end_of_frame <= nxt.last;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, or a long hold-off when one has been requested.
  always @(negedge clk) begin : receiver
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      out_stall   <= 1'b1;
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: tracks requests at the rising edge, predicts and checks verdicts.
  always @(posedge clk) begin : monitor
    verdict_rec_t want;
    verdict_t     v;
    logic         done;
    logic         in_acc;
    logic         out_acc;
    logic         cfg_acc;
    in_acc  = rst_n && in_valid && !in_stall;
    out_acc = rst_n && out_valid && !out_stall;
    cfg_acc = rst_n && cfg_valid && cfg_ready;
    in_taken <= in_acc;

    if (cfg_acc) begin
      case (cfg_index)
        CFG_SERVER_PORT: begin
          want_port = cfg_data[15:0];
        end
        CFG_SERVER_ADDRESS: begin
          want_addr = cfg_data;
        end
        default: begin
        end
      endcase
      cfg_writes <= cfg_writes + 1;
    end

    // Check before predicting: a verdict never leaves in the cycle its byte enters.
    if (out_acc) begin
      if (pending_verdicts.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: verdict with none expected: admit=%0b verdict=%0d",
                   $time, out_admit, out_verdict);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_admit !== want.admit || out_verdict !== want.verdict) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: expected admit=%0b verdict=%0d, got admit=%0b verdict=%0d",
                     $time, want.admit, want.verdict, out_admit, out_verdict);
          mismatches++;
        end
      end
    end

    if (in_acc) begin
      take_byte(in_frame_byte, in_end_of_frame, done, v);
      if (done) pending_verdicts.push_back('{(v <= VERDICT_UDP_OK), v});
    end

    // Watchdog on cycles in which no request moves.
    if (!rst_n || in_acc || out_acc || cfg_acc) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Waits until every byte has gone in and every verdict has come out, then settles.
  // The check runs just after the falling edge so that the sender's update is seen.
  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (frame_bytes_q.size() != 0 || in_valid || pending_verdicts.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    int unsigned target;
    wait_idle();
    target = cfg_writes + 1;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk);
    while (cfg_writes != target);
    cfg_valid <= 1'b0;
  endtask

  // Builds one frame with the given header fields and queues its first len bytes.
  // A negative fill value fills the rest with random bytes.
  task automatic queue_frame(input logic [15:0] et, input logic [7:0] vi, input logic [7:0] pr,
                             input logic [31:0] sa, input logic [15:0] sp,
                             input int unsigned len, input int fillv = -1);
    logic [7:0]  octets [160];
    byte_req_t   r;
    int unsigned port_at;
    for (int i = 0; i < 160; i++) octets[i] = (fillv < 0) ? 8'($urandom) : 8'(fillv);
    octets[POS_TYPE_HI]        = et[15:8];
    octets[POS_TYPE_LO]        = et[7:0];
    octets[POS_VER_IHL]        = vi;
    octets[POS_PROTOCOL]       = pr;
    octets[POS_ADDR_FIRST]     = sa[31:24];
    octets[POS_ADDR_FIRST + 1] = sa[23:16];
    octets[POS_ADDR_FIRST + 2] = sa[15:8];
    octets[POS_ADDR_LAST]      = sa[7:0];
    if ((vi & IHL_MASK) >= MIN_IHL) begin
      port_at = POS_VER_IHL + 4 * (vi & IHL_MASK);
      octets[port_at]     = sp[15:8];
      octets[port_at + 1] = sp[7:0];
    end
    for (int unsigned i = 0; i < len; i++) begin
      r.data = octets[i];
      r.last = (i == len - 1);
      frame_bytes_q.push_back(r);
    end
  endtask

  // Mostly well-formed AoE and UDP frames, with short, malformed and noisy ones mixed in.
  task automatic queue_random_frame(input logic [15:0] port, input logic [31:0] addr);
    int unsigned kind;
    int unsigned ihl;
    int unsigned full;
    logic [15:0] sp;
    logic [31:0] sa;
    logic [7:0]  vi;
    kind = $urandom_range(0, 99);
    ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
    vi   = {IPV4_VERSION[7:4], ihl[3:0]};
    full = POS_VER_IHL + 2 + 4 * ihl;
    sp   = (port == ANY_PORT || $urandom_range(0, 7) == 0) ? 16'($urandom) : port;
    sa   = (addr == ANY_ADDRESS || $urandom_range(0, 7) == 0) ? $urandom : addr;
    if (kind < 15)
      queue_frame(TYPE_AOE, 8'($urandom), 8'($urandom), $urandom, 16'($urandom),
                  $urandom_range(14, 40));
    else if (kind < 55)
      queue_frame(TYPE_IPV4, vi, PROTO_UDP, sa, sp, full + $urandom_range(0, 6));
    else if (kind < 67)
      queue_frame(TYPE_IPV4, vi, PROTO_UDP, sa, sp, $urandom_range(1, full - 1));
    else if (kind < 72)
      queue_frame(TYPE_IPV4, vi ^ {4'($urandom_range(1, 15)), 4'h0}, PROTO_UDP, sa, sp, full);
    else if (kind < 77)
      queue_frame(TYPE_IPV4, {IPV4_VERSION[7:4], 4'($urandom_range(0, 4))}, PROTO_UDP, sa, sp,
                  $urandom_range(14, 60));
    else if (kind < 82)
      queue_frame(TYPE_IPV4, vi, 8'($urandom), sa, sp, full);
    else if (kind < 87)
      queue_frame(16'($urandom), vi, PROTO_UDP, sa, sp, $urandom_range(14, 60));
    else if (kind < 95)
      queue_frame(16'($urandom), 8'($urandom), 8'($urandom), $urandom, 16'($urandom),
                  $urandom_range(1, 60));
    else
      queue_frame(TYPE_IPV4, vi, PROTO_UDP, sa, sp, $urandom_range(128, 150));
  endtask

  // One configuration setting followed by random traffic. On request the receiver
  // then holds off long enough for the block to back up into its input.
  task automatic random_phase(input logic [15:0] port, input logic [31:0] addr,
                              input bit long_hold);
    int unsigned frames;
    int unsigned target;
    write_reg(CFG_SERVER_PORT, {16'($urandom), port});
    write_reg(CFG_SERVER_ADDRESS, addr);
    @(posedge clk);
    target = long_hold ? HOLD_FRAMES : PHASE_FRAMES;
    for (frames = 0; frames < target; frames++) queue_random_frame(port, addr);
    if (long_hold) hold_requests++;
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 20;
    recv_idle_pct = 76;

    // Reset configuration: any port, any address.
    queue_frame(TYPE_AOE, 8'h00, 8'h00, 32'h0, 16'h0, 14);
    queue_frame(TYPE_AOE, 8'h00, 8'h00, 32'h0, 16'h0, 1);
    queue_frame(TYPE_AOE, 8'h00, 8'h00, 32'h0, 16'h0, 13);
    queue_frame(16'h0000, 8'h00, 8'h00, 32'h0, 16'h0000, 30, 0);
    queue_frame(16'hffff, 8'hff, 8'hff, 32'hffff_ffff, 16'hffff, 30, 255);
    queue_frame(TYPE_IPV4, 8'h45, PROTO_UDP, 32'h0, 16'h0, 14);
    queue_frame(TYPE_IPV4, 8'h65, PROTO_UDP, 32'h0, 16'h0, 15);
    queue_frame(TYPE_IPV4, 8'h44, PROTO_UDP, 32'h0, 16'h0, 30);
    queue_frame(TYPE_IPV4, 8'h45, PROTO_UDP, 32'h0, 16'h0, 23);
    queue_frame(TYPE_IPV4, 8'h45, 8'd6, 32'h0, 16'h0, 24);
    queue_frame(TYPE_IPV4, 8'h45, PROTO_UDP, 32'h0, 16'h0, 24);
    // Long frame: the position saturates and the tail is ignored.
    queue_frame(TYPE_IPV4, 8'h45, PROTO_UDP, 32'h0, 16'h0, 130);

    // Writes to an index with no register behind it change nothing.
    write_reg(CFG_UNUSED, $urandom);

    // Address check only: short before the address, then match and mismatch.
    write_reg(CFG_SERVER_ADDRESS, 32'h0a00_0001);
    @(posedge clk);
    queue_frame(TYPE_IPV4, 8'h45, PROTO_UDP, 32'h0a00_0001, 16'h0, 29);
    queue_frame(TYPE_IPV4, 8'h45, PROTO_UDP, 32'h0a00_0001, 16'h0, 30);
    queue_frame(TYPE_IPV4, 8'h45, PROTO_UDP, 32'h0a00_0002, 16'h0, 30);

    // Port and address: wrong port, short port, maximum options, wrong address, short after options.
    write_reg(CFG_SERVER_PORT, 32'h0000_1234);
    @(posedge clk);
    queue_frame(TYPE_IPV4, 8'h45, PROTO_UDP, 32'h0a00_0001, 16'h1235, 36);
    queue_frame(TYPE_IPV4, 8'h45, PROTO_UDP, 32'h0a00_0001, 16'h1234, 35);
    queue_frame(TYPE_IPV4, 8'h4f, PROTO_UDP, 32'h0a00_0001, 16'h1234, 76);
    queue_frame(TYPE_IPV4, 8'h45, PROTO_UDP, 32'h8a00_0001, 16'h1234, 36);
    queue_frame(TYPE_IPV4, 8'h46, PROTO_UDP, 32'h0a00_0001, 16'h1234, 38);

    random_phase(16'($urandom_range(1, 65535)), $urandom, 1'b0);

    // Sender idles heavily, receiver lightly.
    wait_idle();
    @(posedge clk);
    send_idle_pct = 76;
    recv_idle_pct = 20;
    random_phase(16'hffff, 32'h0000_0000, 1'b0);
    random_phase(ANY_PORT, ANY_ADDRESS, 1'b0);

    // No idling; the long hold-off backs the block up into its input.
    wait_idle();
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(16'h0001, 32'hffff_fffe, 1'b1);

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[udp_aoe_frame_admission_filter_top.f]
hdl/afp_pkg.sv
hdl/afp_capture.sv
hdl/afp_judge.sv
hdl/udp_aoe_frame_admission_filter_top.sv
hdl/afp_checker.sv
tb/tb.sv
